// ===== rtl/core/ddrw_pkg.sv =====
// Package for the decimal digit register writer: field widths, driver addresses,
// and the microprogram ROM (control word type and contents).
// Depends on nothing.
package ddrw_pkg;

  localparam int VALUE_W        = 27;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 8;
  localparam int BITCNT_W       = $clog2(VALUE_W);
  localparam int MAX_DIGITS_DEF = 8;

  localparam logic [ADDR_W-1:0] SCAN_LIMIT_ADDR = 4'hB;

  // Largest number that fits in n decimal digits; elaboration only.
  function automatic logic [VALUE_W-1:0] largest_shown(input int n);
    longint lim;
    lim = 1;
    for (int k = 0; k < n; k++) begin
      lim = lim * 10;
    end
    return VALUE_W'(lim - 1);
  endfunction

  typedef logic [2:0] step_t;

  localparam step_t STEP_WAIT  = 3'd0;
  localparam step_t STEP_CONV  = 3'd1;
  localparam step_t STEP_COUNT = 3'd2;
  localparam step_t STEP_SCAN  = 3'd3;
  localparam step_t STEP_DIGIT = 3'd4;

  typedef enum logic [2:0] {
    DP_LOAD,
    DP_DABBLE,
    DP_COUNT,
    DP_SCAN,
    DP_DIGIT
  } dp_op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_START,
    COND_BITS_DONE,
    COND_DIGITS_DONE
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  t_true;
    step_t  t_false;
  } ctrl_word_t;

  // Microprogram: one control word per step.
  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t w;
    case (step)
      STEP_WAIT:  w = '{DP_LOAD,   COND_START,       STEP_CONV,  STEP_WAIT};
      STEP_CONV:  w = '{DP_DABBLE, COND_BITS_DONE,   STEP_COUNT, STEP_CONV};
      STEP_COUNT: w = '{DP_COUNT,  COND_ALWAYS,      STEP_SCAN,  STEP_SCAN};
      STEP_SCAN:  w = '{DP_SCAN,   COND_ALWAYS,      STEP_DIGIT, STEP_DIGIT};
      STEP_DIGIT: w = '{DP_DIGIT,  COND_DIGITS_DONE, STEP_WAIT,  STEP_DIGIT};
      default:    w = '{DP_LOAD,   COND_ALWAYS,      STEP_WAIT,  STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/decimal_digit_register_writer.sv =====
// Decimal digit register writer: binary to BCD by shift-and-add-3, then the
// register writes for a seven-segment digit driver. Uses ddrw_pkg.
//
// Usage:
//   Input channel: drive in_value and raise start; the item is taken at the
//   rising edge where start is high and busy is low. Values above the largest
//   number that MAX_DIGITS decimal digits can show saturate to that number.
//   Result channel: each register write appears on out_reg_address,
//   out_reg_data and out_last for exactly one cycle with out_valid high. The
//   receiver cannot stall; writes come on consecutive cycles.
//   Writes per item: first the scan-limit register (address 11) with the digit
//   count minus one, then digit registers 1..count, least significant digit
//   first, leading zeros suppressed (zero shows as one digit). out_last marks
//   the final write of the item.
// Timing: after acceptance, conversion takes one input bit per cycle through the
//   shared add-3 stage, a count step finds the digit count, then one write per
//   cycle follows: scan limit plus 1..MAX_DIGITS digits. busy stays high until
//   the final write is on the ports; no new item is taken before then.
// Reset: rst_n (synchronous, active low) returns the sequencer to its wait step
//   and drops out_valid; no clearing pass is needed.
module decimal_digit_register_writer #(
  parameter int MAX_DIGITS = ddrw_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ddrw_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  output logic [ddrw_pkg::ADDR_W-1:0]  out_reg_address,
  output logic [ddrw_pkg::DATA_W-1:0]  out_reg_data,
  output logic                         out_last
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [ddrw_pkg::VALUE_W-1:0] TOP = ddrw_pkg::largest_shown(MAX_DIGITS);

  // Sequencer
  ddrw_pkg::step_t      step_r, step_nxt;
  ddrw_pkg::ctrl_word_t cw;
  logic                 cond_ok;

  // Datapath
  logic [ddrw_pkg::VALUE_W-1:0]  val_r, val_nxt;
  logic [BCD_W-1:0]              bcd_r, bcd_nxt, bcd_adj;
  logic [ddrw_pkg::BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt, cnt_calc;
  logic [CNT_W-1:0]              dig_r, dig_nxt;

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  logic [ddrw_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [ddrw_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic                        out_last_r, out_last_nxt;

  assign cw   = ddrw_pkg::ucode_rom(step_r);
  assign busy = (step_r != ddrw_pkg::STEP_WAIT);

  // Evaluate the jump condition of the current control word.
  always_comb begin
    case (cw.cond)
      ddrw_pkg::COND_ALWAYS:      cond_ok = 1'b1;
      ddrw_pkg::COND_START:       cond_ok = start;
      ddrw_pkg::COND_BITS_DONE:   cond_ok = (bit_cnt_r == '0);
      ddrw_pkg::COND_DIGITS_DONE: cond_ok = (dig_r == cnt_r);
      default:                    cond_ok = 1'b0;
    endcase
  end

  assign step_nxt = cond_ok ? cw.t_true : cw.t_false;

  // Add 3 to every BCD digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  // Significant digit count: position of the highest nonzero digit, at least one.
  always_comb begin
    cnt_calc = CNT_W'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        cnt_calc = CNT_W'(i + 1);
      end
    end
  end

  // Datapath actions per control word.
  always_comb begin
    val_nxt       = val_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    cnt_nxt       = cnt_r;
    dig_nxt       = dig_r;
    out_valid_nxt = 1'b0;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = 1'b0;
    case (cw.op)
      ddrw_pkg::DP_LOAD: begin
        // Hold the latest input while waiting; the accepted one stays.
        val_nxt     = (in_value > TOP) ? TOP : in_value;
        bcd_nxt     = '0;
        bit_cnt_nxt = ddrw_pkg::BITCNT_W'(ddrw_pkg::VALUE_W - 1);
      end
      ddrw_pkg::DP_DABBLE: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], val_r[ddrw_pkg::VALUE_W-1]};
        val_nxt     = {val_r[ddrw_pkg::VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - ddrw_pkg::BITCNT_W'(1);
      end
      ddrw_pkg::DP_COUNT: begin
        cnt_nxt = cnt_calc;
      end
      ddrw_pkg::DP_SCAN: begin
        out_valid_nxt = 1'b1;
        out_addr_nxt  = ddrw_pkg::SCAN_LIMIT_ADDR;
        out_data_nxt  = ddrw_pkg::DATA_W'(cnt_r - CNT_W'(1));
        dig_nxt       = CNT_W'(1);
      end
      ddrw_pkg::DP_DIGIT: begin
        // Emit the low digit, advance to the next one.
        out_valid_nxt = 1'b1;
        out_addr_nxt  = ddrw_pkg::ADDR_W'(dig_r);
        out_data_nxt  = ddrw_pkg::DATA_W'(bcd_r[3:0]);
        out_last_nxt  = (dig_r == cnt_r);
        bcd_nxt       = bcd_r >> 4;
        dig_nxt       = dig_r + CNT_W'(1);
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ddrw_pkg::STEP_WAIT;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    val_r      <= val_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    cnt_r      <= cnt_nxt;
    dig_r      <= dig_nxt;
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_reg_address = out_addr_r;
  assign out_reg_data    = out_data_r;
  assign out_last        = out_last_r;

  // An accepted item makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // Writes of one item come back to back until the flagged one.
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a write burst");

  // The scan-limit write is followed by digit register 1.
  a_scan_then_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reg_address == ddrw_pkg::SCAN_LIMIT_ADDR) |=>
      (out_valid && out_reg_address == ddrw_pkg::ADDR_W'(1)))
    else $error("first digit write missing after scan limit");

  // The flagged write ends the burst.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("write after the final one");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for decimal_digit_register_writer: drives numbers
// through the start/busy port and checks every register write it produces.
// Depends on ddrw_pkg and the RTL top level; reads and writes no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W      = ddrw_pkg::VALUE_W;
  localparam int ADDR_W       = ddrw_pkg::ADDR_W;
  localparam int DATA_W       = ddrw_pkg::DATA_W;

  // Largest number that eight digits can show; anything above it saturates.
  localparam int SHOWN_MAX    = 99999999;
  localparam int DIGITS_MAX   = ddrw_pkg::MAX_DIGITS_DEF;
  localparam int RANDOM_ITEMS = 210;
  // Final stretch of the random part runs back to back with no idling.
  localparam int CALM_TAIL    = 40;
  // After the final drain, settle for longer than the longest item occupies the block.
  localparam int DRAIN_CYCLES = 40;
  // Overall budget: about ten times the slowest correct run.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;
  localparam int ROW_COUNT    = 22;

  // One register write as the driver chip would see it.
  typedef struct {
    logic [VALUE_W-1:0] number;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic               last;
  } reg_write_t;

  // Directed row: a number and, where it is obvious, the expected display
  // written out as scan limit plus BCD digits (least significant nibble first).
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               typed;
    logic [DATA_W-1:0]  scan;
    logic [31:0]        bcd;
  } number_row_t;

  localparam number_row_t NUMBER_TABLE [ROW_COUNT] = '{
    // zero shows as one digit 0
    '{27'd0,         1'b1, 8'd0, 32'h0000_0000},
    '{27'd1,         1'b1, 8'd0, 32'h0000_0001},
    '{27'd9,         1'b1, 8'd0, 32'h0000_0009},
    '{27'd10,        1'b1, 8'd1, 32'h0000_0010},
    '{27'd99,        1'b1, 8'd1, 32'h0000_0099},
    '{27'd100,       1'b1, 8'd2, 32'h0000_0100},
    '{27'd12345678,  1'b1, 8'd7, 32'h1234_5678},
    '{27'd10000000,  1'b1, 8'd7, 32'h1000_0000},
    '{27'd9999999,   1'b1, 8'd6, 32'h0999_9999},
    '{27'd99999999,  1'b1, 8'd7, 32'h9999_9999},
    // too large: saturate to all nines
    '{27'd100000000, 1'b1, 8'd7, 32'h9999_9999},
    '{27'h7FF_FFFF,  1'b1, 8'd7, 32'h9999_9999},
    // digit-count boundaries and bit patterns go through the predictor
    '{27'd1000,      1'b0, 8'd0, 32'h0},
    '{27'd9999,      1'b0, 8'd0, 32'h0},
    '{27'd10000,     1'b0, 8'd0, 32'h0},
    '{27'd99999,     1'b0, 8'd0, 32'h0},
    '{27'd100000,    1'b0, 8'd0, 32'h0},
    '{27'd999999,    1'b0, 8'd0, 32'h0},
    '{27'd1000000,   1'b0, 8'd0, 32'h0},
    '{27'h555_5555,  1'b0, 8'd0, 32'h0},
    '{27'h2AA_AAAA,  1'b0, 8'd0, 32'h0},
    '{27'h400_0000,  1'b0, 8'd0, 32'h0}
  };

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic [ADDR_W-1:0]  out_reg_address;
  logic [DATA_W-1:0]  out_reg_data;
  logic               out_last;

  reg_write_t pending_writes [$];
  int         mismatches;
  int         writes_checked;
  int         numbers_sent;
  int         saturated_numbers;
  int         digit_hist [1:DIGITS_MAX];
  int         cycle_count;

  decimal_digit_register_writer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_reg_address (out_reg_address),
    .out_reg_data    (out_reg_data),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops writes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d writes still expected",
               cycle_count, pending_writes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int ten_to(input int n);
    int p;
    p = 1;
    for (int k = 0; k < n; k++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Work out what the display should show: clamp, count significant digits,
  // and split into BCD nibbles.
  task automatic predict_display(input logic [VALUE_W-1:0] value,
                                 output logic [DATA_W-1:0] scan,
                                 output logic [31:0] bcd);
    int shown;
    int rest;
    int digits;
    shown = int'(value);
    if (shown > SHOWN_MAX) begin
      shown = SHOWN_MAX;
    end
    rest = shown;
    digits = 0;
    do begin
      digits++;
      rest = rest / 10;
    end while (rest != 0 && digits < DIGITS_MAX);
    scan = DATA_W'(digits - 1);
    bcd = '0;
    rest = shown;
    for (int k = 0; k < digits; k++) begin
      bcd[4*k +: 4] = 4'(rest % 10);
      rest = rest / 10;
    end
  endtask

  // Turn a display into the write sequence: scan limit, then digits 1..n.
  task automatic queue_writes(input logic [VALUE_W-1:0] value,
                              input logic [DATA_W-1:0] scan,
                              input logic [31:0] bcd);
    reg_write_t w;
    int count;
    count = int'(scan) + 1;
    w.number = value;
    w.addr   = ddrw_pkg::SCAN_LIMIT_ADDR;
    w.data   = scan;
    w.last   = 1'b0;
    pending_writes.push_back(w);
    for (int k = 1; k <= count; k++) begin
      w.addr = ADDR_W'(k);
      w.data = DATA_W'(bcd[4*(k-1) +: 4]);
      w.last = (k == count);
      pending_writes.push_back(w);
    end
    digit_hist[count]++;
  endtask

  // Present one item and hold it until the block takes it.
  task automatic drive_number(input logic [VALUE_W-1:0] value, input logic typed,
                              input logic [DATA_W-1:0] typed_scan,
                              input logic [31:0] typed_bcd);
    logic [DATA_W-1:0] scan;
    logic [31:0] bcd;
    start    <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (busy);
    if (typed) begin
      scan = typed_scan;
      bcd  = typed_bcd;
    end else begin
      predict_display(value, scan, bcd);
    end
    queue_writes(value, scan, bcd);
    numbers_sent++;
    if (int'(value) > SHOWN_MAX) begin
      saturated_numbers++;
    end
  endtask

  // Drop start and hold off until every expected write has come out.
  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  // Idle the sender half of the time: right away (gap falls while the block converts)
  // or after the block goes idle (gap seen on an idle block); else send at once.
  task automatic idle_burst();
    case ($urandom_range(0, 3))
      0: begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      1: begin
        start <= 1'b0;
        do @(posedge clk); while (busy);
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      default: begin
      end
    endcase
  endtask

  // Random numbers: mostly a chosen digit count so every length shows up, plus powers
  // of ten and the numbers just below them, raw 27-bit words and tiny values.
  function automatic logic [VALUE_W-1:0] pick_number();
    int mode;
    int d;
    int lo;
    int hi;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      d  = $urandom_range(1, DIGITS_MAX);
      lo = (d == 1) ? 0 : ten_to(d - 1);
      hi = ten_to(d) - 1;
      return VALUE_W'(lo + $urandom_range(0, hi - lo));
    end else if (mode == 6) begin
      return VALUE_W'(ten_to($urandom_range(0, DIGITS_MAX)) - $urandom_range(0, 1));
    end else if (mode <= 8) begin
      return VALUE_W'($urandom());
    end
    return VALUE_W'($urandom_range(0, 20));
  endfunction

  task automatic flag_mismatch(input string what, input reg_write_t want,
                               input int got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("Mismatch on %s for number %0d: expected %0d, got %0d (cycle %0d)",
               what, want.number, (what == "address") ? want.addr :
               (what == "data") ? want.data : want.last, got, cycle_count);
    end
  endtask

  // Result checker: the receiver cannot stall, so take every strobed write
  // and compare it with the oldest expectation.
  always @(posedge clk) begin
    reg_write_t want;
    if (rst_n && out_valid) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("Unexpected write: address %0d data %0d last %0b (cycle %0d)",
                   out_reg_address, out_reg_data, out_last, cycle_count);
        end
      end else begin
        want = pending_writes.pop_front();
        writes_checked++;
        if (out_reg_address !== want.addr) begin
          flag_mismatch("address", want, out_reg_address);
        end
        if (out_reg_data !== want.data) begin
          flag_mismatch("data", want, out_reg_data);
        end
        if (out_last !== want.last) begin
          flag_mismatch("last", want, out_last);
        end
      end
    end
  end

  initial begin
    number_row_t row;
    // Hold every input at a known value from time zero.
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    foreach (digit_hist[k]) begin
      digit_hist[k] = 0;
    end

    // Hold reset at the start, then release it once for the whole run.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the table back to back.
    for (int i = 0; i < ROW_COUNT; i++) begin
      row = NUMBER_TABLE[i];
      drive_number(row.value, row.typed, row.scan, row.bcd);
    end
    pause_until_drained();

    // Random part: idle in bursts early on, stop once in the middle until
    // every write has drained, and run flat out through the tail.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        pause_until_drained();
      end else if (i < RANDOM_ITEMS - CALM_TAIL) begin
        idle_burst();
      end
      drive_number(pick_number(), 1'b0, '0, '0);
    end

    // Drain the last writes, then watch a little longer for strays.
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_writes.size() != 0) begin
      mismatches++;
      $display("%0d expected writes never arrived", pending_writes.size());
    end
    $display("Sent %0d numbers (%0d saturated), checked %0d register writes, %0d mismatches",
             numbers_sent, saturated_numbers, writes_checked, mismatches);
    $display("Numbers per digit count 1..8: %0d %0d %0d %0d %0d %0d %0d %0d",
             digit_hist[1], digit_hist[2], digit_hist[3], digit_hist[4],
             digit_hist[5], digit_hist[6], digit_hist[7], digit_hist[8]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
